@@ rtl/bang_bang_clock_recovery_assert.svh @@
// assertion macros for the clock recovery block
`ifndef BANG_BANG_CLOCK_RECOVERY_ASSERT_SVH
`define BANG_BANG_CLOCK_RECOVERY_ASSERT_SVH
// implication checked every clock outside reset
`define BBCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define BBCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/bbcr_pkg.sv @@
// shared types and constants for the clock recovery block
package bbcr_pkg;
  localparam int unsigned MaxUiPerEdge = 64;
  localparam int unsigned TimeFracBits = 8;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CfgNominalPeriod = 2'd0,
    CfgPeriodGain    = 2'd1,
    CfgPhaseGain     = 2'd2,
    CfgOutputOffset  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [55:0] edge_time;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [47:0] clock_time;
    logic [19:0] clock_period;
    logic        clock_level;
    logic        last_of_run;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // scaled edge handed from front to back
  typedef struct packed {
    logic [63:0] t16;
    logic        is_last;
  } cmd_t;
endpackage

@@ rtl/bbcr_front.sv @@
// front end: accepts edges, scales them and queues them for the nco
module bbcr_front #(
  parameter int unsigned TimeFracBits = bbcr_pkg::TimeFracBits,
  parameter int unsigned QueueDepth   = bbcr_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbcr_pkg::in_item_t  in_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output bbcr_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i
);
  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FracGap = 16 - TimeFracBits;

  bbcr_pkg::cmd_t mem_q [QueueDepth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;
  bbcr_pkg::cmd_t cmd_in;

  assign in_ready_o  = (cnt_q != (AW+1)'(QueueDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign cmd_in.t16 = 64'(in_data_i.edge_time) << FracGap;
  assign cmd_in.is_last = in_data_i.is_last;
  assign cmd_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == AW'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

@@ rtl/bbcr_back.sv @@
// back end: nco sequencer that emits unit intervals and applies feedback
`include "bang_bang_clock_recovery_assert.svh"
module bbcr_back #(
  parameter int unsigned MaxUiPerEdge = bbcr_pkg::MaxUiPerEdge,
  parameter int unsigned TimeFracBits = bbcr_pkg::TimeFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbcr_pkg::cmd_t      cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  logic [27:0]         nominal_period_i,
  input  logic [31:0]         period_gain_i,
  input  logic [31:0]         phase_gain_i,
  input  logic [23:0]         output_offset_i,
  output bbcr_pkg::out_item_t out_data_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);
  localparam int unsigned FracGap = 16 - TimeFracBits;
  localparam logic [47:0] Mask48 = '1;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StCheck = 8'b0000_0010,
    StMulA  = 8'b0000_0100,
    StMulB  = 8'b0000_1000,
    StPer   = 8'b0001_0000,
    StMulC  = 8'b0010_0000,
    StPhase = 8'b0100_0000,
    StEmit  = 8'b1000_0000
  } st_e;

  st_e         st_q;
  logic        running_q;
  logic [63:0] pos_q, start_q, t_q;
  logic [47:0] per_q, half_q;
  logic [6:0]  olc_q;
  logic        clk_state_q, last_q, late_q;
  logic [6:0]  n_q;
  logic [63:0] prod_q;
  logic [63:0] step_q;
  logic [31:0] gain_q;
  logic        phase_pass_q;
  logic        out_valid_q;
  bbcr_pkg::out_item_t out_q;

  // absorb / late compare
  logic [63:0] d_half, d_per;
  logic        absorb, late;
  assign d_half = pos_q - t_q - 64'(half_q);
  assign d_per  = pos_q - t_q - 64'(per_q);
  assign absorb = (d_half != '0) && !d_half[63];
  assign late   = (d_per != '0) && !d_per[63];

  // outcome of the check that follows the interval being emitted
  logic [63:0] pos_next, d_next;
  logic        absorb_next, at_limit;
  assign pos_next    = pos_q + 64'(per_q);
  assign d_next      = pos_next - t_q - 64'(per_q >> 1);
  assign absorb_next = (d_next != '0) && !d_next[63];
  assign at_limit    = (n_q + 7'd1) >= 7'(MaxUiPerEdge);

  // emit fields of the open interval
  logic [63:0] base, off, diff;
  logic [47:0] ctime;
  logic [19:0] cper;
  assign base = start_q + 64'(per_q >> 1);
  assign off  = 64'(output_offset_i) << FracGap;
  assign diff = base - off + 64'h8000;
  assign ctime = (base >= off) ? diff[63:16] : '0;
  assign cper  = (per_q[47:36] != '0) ? 20'hFFFFF : per_q[35:16];

  // frac_mul: one 32x32 multiplier, high half then low half
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  assign mul_a = (st_q == StMulA) ? prod_q[63:32] : prod_q[31:0];
  assign mul_p = 64'(mul_a) * 64'(gain_q);

  logic [63:0] per_plus;
  assign per_plus = 64'(per_q) + step_q;

  logic out_free, emit_go;
  assign out_free = !out_valid_q || out_ready_i;
  assign emit_go  = (st_q == StEmit) && out_free;
  assign cmd_ready_o = (st_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && cmd_valid_i) begin
      t_q <= cmd_i.t16;
      last_q <= cmd_i.is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      running_q <= 1'b0;
      pos_q <= '0;
      start_q <= '0;
      per_q <= 48'(28'd204800) << FracGap;
      half_q <= '0;
      olc_q <= '0;
      clk_state_q <= 1'b0;
      late_q <= 1'b0;
      n_q <= '0;
      prod_q <= '0;
      step_q <= '0;
      gain_q <= '0;
      phase_pass_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      case (st_q)
        StIdle: begin
          n_q <= '0;
          if (cmd_valid_i) st_q <= StCheck;
        end
        StCheck: begin
          if (!running_q) begin
            st_q <= StIdle;
            if (!last_q) begin
              per_q <= 48'(nominal_period_i) << FracGap;
              clk_state_q <= 1'b0;
              running_q <= 1'b1;
              pos_q <= t_q;
              start_q <= t_q;
              half_q <= (48'(nominal_period_i) << FracGap) >> 1;
              olc_q <= 7'd1;
            end
          end else if (last_q) begin
            st_q <= StEmit;
          end else if (absorb) begin
            late_q <= late;
            prod_q <= per_q * 64'(olc_q);
            gain_q <= period_gain_i;
            phase_pass_q <= 1'b0;
            st_q <= StMulA;
          end else if (n_q >= 7'(MaxUiPerEdge)) begin
            // re-sync; overflow already went out on the final emitted beat
            pos_q <= t_q;
            start_q <= t_q;
            half_q <= per_q >> 1;
            olc_q <= 7'd1;
            st_q <= StIdle;
          end else begin
            st_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            clk_state_q <= !clk_state_q;
            out_q.clock_time <= ctime;
            out_q.clock_period <= cper;
            out_q.clock_level <= !clk_state_q;
            if (last_q) begin
              out_q.last_of_run <= 1'b1;
              out_q.overflow <= 1'b0;
              running_q <= 1'b0;
              st_q <= StIdle;
            end else begin
              // last_of_run marks a beat after which the next check absorbs the edge or hits the limit
              out_q.last_of_run <= absorb_next || at_limit;
              out_q.overflow <= !absorb_next && at_limit;
              n_q <= n_q + 7'd1;
              pos_q <= pos_next;
              start_q <= pos_next;
              half_q <= per_q >> 1;
              if (olc_q != 7'd127) olc_q <= olc_q + 7'd1;
              st_q <= StCheck;
            end
          end
        end
        StMulA: begin
          step_q <= mul_p;
          st_q <= StMulB;
        end
        StMulB: begin
          step_q <= step_q + (mul_p >> 32);
          st_q <= phase_pass_q ? StPhase : StPer;
        end
        StPer: begin
          if (late_q) begin
            per_q <= (step_q > 64'(per_q)) ? '0 : per_q - step_q[47:0];
          end else begin
            per_q <= (per_plus > 64'(Mask48)) ? Mask48 : per_plus[47:0];
          end
          st_q <= StMulC;
        end
        StMulC: begin
          prod_q <= per_q * 64'(olc_q);
          gain_q <= phase_gain_i;
          phase_pass_q <= 1'b1;
          st_q <= StMulA;
        end
        StPhase: begin
          pos_q <= late_q ? pos_q - step_q : pos_q + step_q;
          olc_q <= '0;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sequencer sanity
  `BBCR_ASSERT_IMP(a_emit_one_hot, 1'b1, $onehot(st_q))
  `BBCR_ASSERT_NEXT(a_idle_after_phase, st_q == StPhase, st_q == StIdle)
  `BBCR_ASSERT_IMP(a_cnt_limit, 1'b1, n_q <= 7'(MaxUiPerEdge))
endmodule

@@ rtl/bang_bang_clock_recovery.sv @@
// An edge leaves the front queue when the nco is idle; StCheck then starts the nco,
// or alternates with StEmit per interval, StEmit waiting on output stalls. An absorbed
// edge then runs feedback through one shared 32x32 multiplier in StMulA, StMulB, StPer,
// StMulC, StMulA, StMulB and StPhase; a two-beat queue in front holds the next edges.
// Reset: asynchronous active low; control and config registers to defaults, nco idle.
module bang_bang_clock_recovery #(
  parameter int unsigned MaxUiPerEdge = bbcr_pkg::MaxUiPerEdge,
  parameter int unsigned TimeFracBits = bbcr_pkg::TimeFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbcr_pkg::in_item_t  in_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output bbcr_pkg::out_item_t out_data_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bbcr_pkg::cfg_item_t cfg_data_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o
);
  logic [27:0] nom_q;
  logic [31:0] pgain_q, fgain_q;
  logic [23:0] off_q;
  bbcr_pkg::cmd_t cmd;
  logic cmd_valid, cmd_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_q <= 28'd204800;
      pgain_q <= 32'd107374;
      fgain_q <= 32'd10737418;
      off_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_data_i.index)
        bbcr_pkg::CfgNominalPeriod: nom_q <= cfg_data_i.data[27:0];
        bbcr_pkg::CfgPeriodGain:    pgain_q <= cfg_data_i.data;
        bbcr_pkg::CfgPhaseGain:     fgain_q <= cfg_data_i.data;
        bbcr_pkg::CfgOutputOffset:  off_q <= cfg_data_i.data[23:0];
        default: ;
      endcase
    end
  end

  bbcr_front #(.TimeFracBits(TimeFracBits)) u_front (
    .clk_i, .rst_ni, .in_data_i, .in_valid_i, .in_ready_o,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  bbcr_back #(.MaxUiPerEdge(MaxUiPerEdge), .TimeFracBits(TimeFracBits)) u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .nominal_period_i(nom_q), .period_gain_i(pgain_q), .phase_gain_i(fgain_q),
    .output_offset_i(off_q), .out_data_o, .out_valid_o, .out_ready_i
  );
endmodule

@@ sim/tb_bang_bang_clock_recovery.sv @@
// testbench for the bang-bang clock recovery block: directed table, random edge runs, nco predictor
module tb_bang_bang_clock_recovery;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracGap = 16 - bbcr_pkg::TimeFracBits;
  localparam logic [63:0] Mask48 = 64'hFFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bbcr_pkg::in_item_t in_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  bbcr_pkg::out_item_t out_data;
  logic out_valid;
  logic out_ready = 1'b0;
  bbcr_pkg::cfg_item_t cfg_data = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;

  always #10 clk_i = ~clk_i;

  bang_bang_clock_recovery i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .out_data_o (out_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .cfg_data_i (cfg_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready)
  );

  // register shadow
  logic [27:0] nom_period;
  logic [31:0] per_gain, ph_gain;
  logic [23:0] out_offset;
  // nco shadow
  logic        nco_on;
  logic [63:0] nco_pos, ui_start, nco_per, ui_half;
  logic [6:0]  ol_count;
  logic        lvl;

  bbcr_pkg::out_item_t clock_edges_q[$];
  int errors = 0;
  int pred_n = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [63:0] gain_mul(input logic [63:0] x, input logic [31:0] g);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = 64'(x[63:32]) * 64'(g);
    lo = (64'(x[31:0]) * 64'(g)) >> 32;
    return hi + lo;
  endfunction

  function automatic void open_interval();
    ui_start = nco_pos;
    ui_half = nco_per >> 1;
    if (ol_count < 7'd127) ol_count++;
  endfunction

  function automatic bbcr_pkg::out_item_t close_interval();
    bbcr_pkg::out_item_t r;
    logic [63:0] base, off, p;
    base = ui_start + (nco_per >> 1);
    off = 64'(out_offset) << FracGap;
    r = '0;
    if (base >= off) r.clock_time = 48'((base - off + 64'h8000) >> 16);
    p = nco_per >> 16;
    r.clock_period = (p > 64'hFFFFF) ? 20'hFFFFF : p[19:0];
    lvl = ~lvl;
    r.clock_level = lvl;
    return r;
  endfunction

  function automatic bit pos_diff(input logic [63:0] d);
    return d != 0 && !d[63];
  endfunction

  function automatic void predict_edge(input bbcr_pkg::in_item_t it);
    logic [63:0] t16, step;
    bbcr_pkg::out_item_t res[$];
    bit late;
    int n;
    t16 = 64'(it.edge_time) << FracGap;
    pred_n = 0;
    if (!nco_on) begin
      if (it.is_last) return;
      nco_per = (64'(nom_period) << FracGap) & Mask48;
      lvl = 0;
      nco_on = 1;
      nco_pos = t16;
      ol_count = 0;
      open_interval();
      return;
    end
    if (it.is_last) begin
      res = {res, close_interval()};
      res[0].last_of_run = 1;
      nco_on = 0;
      clock_edges_q = {clock_edges_q, res[0]};
      pred_n = 1;
      return;
    end
    n = 0;
    forever begin
      if (pos_diff(nco_pos - t16 - ui_half)) begin
        late = pos_diff(nco_pos - t16 - nco_per);
        step = gain_mul(nco_per * 64'(ol_count), per_gain);
        if (late) nco_per = (step > nco_per) ? 64'd0 : nco_per - step;
        else begin
          nco_per = nco_per + step;
          if (nco_per > Mask48) nco_per = Mask48;
        end
        step = gain_mul(nco_per * 64'(ol_count), ph_gain);
        nco_pos = late ? nco_pos - step : nco_pos + step;
        ol_count = 0;
        break;
      end
      if (n >= int'(bbcr_pkg::MaxUiPerEdge)) begin
        nco_pos = t16;
        ol_count = 0;
        open_interval();
        if (n > 0) res[n-1].overflow = 1;
        break;
      end
      res = {res, close_interval()};
      n++;
      nco_pos = nco_pos + nco_per;
      open_interval();
    end
    if (n > 0) res[n-1].last_of_run = 1;
    foreach (res[i]) clock_edges_q = {clock_edges_q, res[i]};
    pred_n = n;
  endfunction

  function automatic void shadow_reset();
    nom_period = 28'd204800;
    per_gain = 32'd107374;
    ph_gain = 32'd10737418;
    out_offset = 24'd0;
    nco_on = 0;
    nco_pos = 0;
    ui_start = 0;
    nco_per = (64'(nom_period) << FracGap) & Mask48;
    ol_count = 0;
    lvl = 0;
    ui_half = 0;
  endfunction

  task automatic write_reg(input bbcr_pkg::cfg_idx_e idx, input logic [31:0] val);
    cfg_data <= '{index: idx, data: val};
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      bbcr_pkg::CfgNominalPeriod: nom_period = val[27:0];
      bbcr_pkg::CfgPeriodGain:    per_gain = val;
      bbcr_pkg::CfgPhaseGain:     ph_gain = val;
      bbcr_pkg::CfgOutputOffset:  out_offset = val[23:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (clock_edges_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // one item; gap drawn per item, 0 in no-idle stretches; valid stays up after the beat
  task automatic send_edge(input logic [55:0] t, input logic last, input bit busy);
    bbcr_pkg::in_item_t it;
    int unsigned gap;
    it.edge_time = t;
    it.is_last = last;
    gap = busy ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    predict_edge(it);
  endtask

  // receiver
  int unsigned rx_wait;
  int unsigned rx_mode;
  initial begin
    bbcr_pkg::out_item_t e;
    @(posedge rst_ni);
    forever begin
      rx_wait = (rx_mode == 0) ? $urandom_range(0, 8) : 0;
      if (hold_off || rx_wait > 0) begin
        out_ready <= 1'b0;
        while (hold_off) @(posedge clk_i);
        repeat (rx_wait) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      if (clock_edges_q.size() == 0) report("clock edge with none expected");
      else begin
        e = clock_edges_q.pop_front();
        if (out_data.clock_time !== e.clock_time)
          report($sformatf("clock_time %0d exp %0d", out_data.clock_time, e.clock_time));
        if (out_data.clock_period !== e.clock_period)
          report($sformatf("clock_period %0d exp %0d", out_data.clock_period,
                           e.clock_period));
        if (out_data.clock_level !== e.clock_level) report("clock_level");
        if (out_data.last_of_run !== e.last_of_run) report("last_of_run");
        if (out_data.overflow !== e.overflow) report("overflow");
      end
    end
  end

  initial begin
    rx_mode = 0;
    forever begin
      repeat (500) @(posedge clk_i);
      rx_mode = $urandom_range(0, 2) == 0;
    end
  end

  // directed table: edge time, last flag, expected count of clock edges (-1: predictor only)
  typedef struct {
    logic [55:0] t;
    logic        last;
    int          n_exp;
  } row_t;
  row_t dir_rows[$];

  task automatic random_run(input int unsigned n_edges, input bit busy);
    logic [55:0] t;
    logic [63:0] per;
    int unsigned k, mode;
    t = 56'($urandom) << $urandom_range(0, 20);
    send_edge(t, 1'b0, busy);
    per = 64'(nom_period);
    for (k = 0; k < n_edges; k++) begin
      mode = $urandom_range(0, 19);
      if (mode < 14) begin
        // about one interval later, with jitter and some multi-ui gaps
        t = t + 56'(per * $urandom_range(1, 3)) + 56'($urandom_range(0, 40)) - 56'd20;
      end else if (mode < 17) begin
        t = t + 56'(per * $urandom_range(1, 8)) / 2;
      end else if (mode == 17) begin
        t = t + 56'(per * 70);
      end else if (mode == 18) begin
        t = t - 56'($urandom_range(0, 500));
      end else begin
        t = {$urandom, $urandom};
      end
      send_edge(t, 1'b0, busy);
    end
    send_edge(t, 1'b1, busy);
    in_valid <= 1'b0;
  endtask

  int unsigned sent;
  initial begin
    shadow_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: period 800 ps; one interval ahead of a start at 0
    dir_rows.push_back('{56'd0, 1'b1, 0});          // idle last: nothing
    dir_rows.push_back('{56'd0, 1'b0, 0});          // start: nothing
    dir_rows.push_back('{56'd204800, 1'b0, 2});     // two intervals close
    dir_rows.push_back('{56'd409600, 1'b0, 1});
    dir_rows.push_back('{56'd409700, 1'b0, -1});
    dir_rows.push_back('{56'd614300, 1'b0, -1});    // early edge
    dir_rows.push_back('{56'd1000000, 1'b0, -1});   // multi-ui gap
    dir_rows.push_back('{56'd1000000, 1'b0, -1});   // repeated time
    dir_rows.push_back('{56'd900000, 1'b0, -1});    // decreasing time
    dir_rows.push_back('{56'd200000000, 1'b0, 64}); // overflow re-sync
    dir_rows.push_back('{56'd200204800, 1'b0, -1});
    dir_rows.push_back('{56'd0, 1'b1, 1});          // flush
    dir_rows.push_back('{56'hFF_FFFF_FFFF_FF00, 1'b0, 0}); // start near top
    dir_rows.push_back('{56'hFF_FFFF_FFFF_FFFF, 1'b0, -1});
    dir_rows.push_back('{56'h00_0000_0003_2000, 1'b0, -1}); // wrap
    dir_rows.push_back('{56'hFF_FFFF_FFFF_FFFF, 1'b1, 1});
    dir_rows.push_back('{56'd0, 1'b1, 0});
    foreach (dir_rows[i]) begin
      send_edge(dir_rows[i].t, dir_rows[i].last, 1'b1);
      if (dir_rows[i].n_exp >= 0 && pred_n != dir_rows[i].n_exp)
        report($sformatf("row %0d: %0d clock edges predicted, table says %0d", i,
                         pred_n, dir_rows[i].n_exp));
    end
    in_valid <= 1'b0;
    drain();

    // gains and offset at extremes
    write_reg(bbcr_pkg::CfgNominalPeriod, 32'd256);
    write_reg(bbcr_pkg::CfgPeriodGain, 32'hFFFF_FFFF);
    write_reg(bbcr_pkg::CfgPhaseGain, 32'hFFFF_FFFF);
    write_reg(bbcr_pkg::CfgOutputOffset, 32'hFF_FFFF);
    random_run(8, 1'b1);
    drain();
    write_reg(bbcr_pkg::CfgNominalPeriod, 32'h0FFF_FFFF);
    write_reg(bbcr_pkg::CfgPeriodGain, 32'd0);
    write_reg(bbcr_pkg::CfgPhaseGain, 32'd0);
    write_reg(bbcr_pkg::CfgOutputOffset, 32'd0);
    random_run(6, 1'b1);
    drain();

    // long receiver hold-off while edges keep coming
    write_reg(bbcr_pkg::CfgNominalPeriod, 32'd204800);
    write_reg(bbcr_pkg::CfgPeriodGain, 32'd107374);
    write_reg(bbcr_pkg::CfgPhaseGain, 32'd10737418);
    write_reg(bbcr_pkg::CfgOutputOffset, 32'd384);
    hold_off = 1;
    fork
      begin repeat (400) @(posedge clk_i); hold_off = 0; end
      random_run(20, 1'b0);
    join
    drain();

    sent = 0;
    while (sent < 240) begin
      write_reg(bbcr_pkg::CfgNominalPeriod, $urandom_range(256, 600000));
      write_reg(bbcr_pkg::CfgPeriodGain,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000000));
      write_reg(bbcr_pkg::CfgPhaseGain,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50000000));
      write_reg(bbcr_pkg::CfgOutputOffset, $urandom_range(0, 24'hFF_FFFF));
      random_run(38, $urandom_range(0, 3) != 0);
      sent += 40;
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0) $display("tb_bang_bang_clock_recovery: PASS");
    else $display("tb_bang_bang_clock_recovery: FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_bang_bang_clock_recovery: FAIL");
    $finish;
  end
endmodule
